>>> rtl/kline_pkg.sv
`timescale 1ns / 1ps

package kline_pkg;

   localparam int OP_WIDTH            = 2;
   localparam int ADDR_WIDTH          = 8;
   localparam int DUR_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int COUNTER_WIDTH_DEFAULT = 16;

   typedef logic [OP_WIDTH-1:0] op_type;

   localparam op_type OP_TICK = 2'd0;
   localparam op_type OP_FAST = 2'd1;
   localparam op_type OP_FIVE = 2'd2;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_BIT_TICKS   = 3'd0;
   localparam csr_index_type CSR_WAKE_LOW    = 3'd1;
   localparam csr_index_type CSR_WAKE_HIGH   = 3'd2;
   localparam csr_index_type CSR_FUNCTIONAL  = 3'd3;

   localparam logic [DUR_WIDTH-1:0] BIT_TICKS_RESET = 16'd200;
   localparam logic [DUR_WIDTH-1:0] WAKE_RESET      = 16'd25;

   typedef struct packed {
      logic [DUR_WIDTH-1:0] bit_ticks;
      logic [DUR_WIDTH-1:0] wake_low_ticks;
      logic [DUR_WIDTH-1:0] wake_high_ticks;
      logic                 functional_mode;
   } cfg_type;

   // physical addressing: force odd parity through bit 7 when bits 0..6 are even
   function automatic logic [ADDR_WIDTH-1:0] add_parity(input logic [ADDR_WIDTH-1:0] addr,
                                                        input logic functional);
      logic [ADDR_WIDTH-1:0] res;
      res = addr;
      if (!functional && !(^addr[ADDR_WIDTH-2:0])) begin
         res[ADDR_WIDTH-1] = 1'b1;
      end
      return res;
   endfunction

endpackage

>>> rtl/kline_cfg_regs.sv
`timescale 1ns / 1ps

module kline_cfg_regs (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kline_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kline_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output kline_pkg::cfg_type                     cfg
);
   import kline_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIT_TICKS:  cfg_in.bit_ticks       = csr_wdata[DUR_WIDTH-1:0];
            CSR_WAKE_LOW:   cfg_in.wake_low_ticks  = csr_wdata[DUR_WIDTH-1:0];
            CSR_WAKE_HIGH:  cfg_in.wake_high_ticks = csr_wdata[DUR_WIDTH-1:0];
            CSR_FUNCTIONAL: cfg_in.functional_mode = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks       <= BIT_TICKS_RESET;
         cfg_ff.wake_low_ticks  <= WAKE_RESET;
         cfg_ff.wake_high_ticks <= WAKE_RESET;
         cfg_ff.functional_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/kline_seq.sv
`timescale 1ns / 1ps

module kline_seq #(
   parameter int COUNTER_WIDTH = kline_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  kline_pkg::op_type                 op,
   input  logic [kline_pkg::ADDR_WIDTH-1:0]  addr,
   input  kline_pkg::cfg_type                cfg,
   output logic                              line_high,
   output logic                              busy,
   output logic                              done
);
   import kline_pkg::*;

   localparam int CMP_WIDTH = ((COUNTER_WIDTH > DUR_WIDTH) ? COUNTER_WIDTH : DUR_WIDTH) + 1;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_FAST_LOW  = 3'd1;
   localparam logic [2:0] PH_FAST_HIGH = 3'd2;
   localparam logic [2:0] PH_FB_START  = 3'd3;
   localparam logic [2:0] PH_FB_DATA   = 3'd4;
   localparam logic [2:0] PH_FB_STOP   = 3'd5;

   logic [2:0]               phase_ff, phase_in;
   logic [3:0]               bit_index_ff, bit_index_in;
   logic [ADDR_WIDTH-1:0]    shift_ff, shift_in;
   logic [COUNTER_WIDTH-1:0] tick_ff, tick_in;
   logic                     level_ff, level_in;

   logic                     idle;
   logic [DUR_WIDTH-1:0]     dur;
   logic [CMP_WIDTH-1:0]     tick_plus;
   logic                     ends;
   logic [COUNTER_WIDTH-1:0] tick_adv;
   logic [3:0]               bit_next;
   logic                     done_c;

   assign idle = (phase_ff == PH_IDLE);

   always_comb begin
      case (phase_ff)
         PH_FAST_LOW:  dur = cfg.wake_low_ticks;
         PH_FAST_HIGH: dur = cfg.wake_high_ticks;
         default:      dur = cfg.bit_ticks;
      endcase
   end

   assign tick_plus = CMP_WIDTH'(tick_ff) + CMP_WIDTH'(1);
   assign ends      = (tick_ff == {COUNTER_WIDTH{1'b1}}) || (tick_plus >= CMP_WIDTH'(dur));
   assign tick_adv  = ends ? '0 : tick_plus[COUNTER_WIDTH-1:0];
   assign bit_next  = bit_index_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      tick_in      = tick_ff;
      level_in     = level_ff;
      done_c       = 1'b0;
      unique case (op)
         OP_TICK: begin
            if (!idle) begin
               unique case (phase_ff)
                  PH_FAST_LOW: begin
                     tick_in = tick_adv;
                     if (ends) begin
                        phase_in = PH_FAST_HIGH;
                        level_in = 1'b1;
                     end
                  end
                  PH_FAST_HIGH: begin
                     tick_in = tick_adv;
                     if (ends) begin
                        phase_in = PH_IDLE;
                        level_in = 1'b1;
                        done_c   = 1'b1;
                     end
                  end
                  PH_FB_START: begin
                     tick_in = tick_adv;
                     if (ends) begin
                        phase_in     = PH_FB_DATA;
                        bit_index_in = 4'd0;
                        level_in     = shift_ff[0];
                     end
                  end
                  PH_FB_DATA: begin
                     tick_in = tick_adv;
                     if (ends) begin
                        bit_index_in = bit_next;
                        if (bit_next >= 4'd8) begin
                           phase_in = PH_FB_STOP;
                           level_in = 1'b1;
                        end else begin
                           level_in = shift_ff[bit_next[2:0]];
                        end
                     end
                  end
                  PH_FB_STOP: begin
                     tick_in = tick_adv;
                     if (ends) begin
                        phase_in     = PH_IDLE;
                        bit_index_in = 4'd0;
                        level_in     = 1'b1;
                        done_c       = 1'b1;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
         OP_FAST: begin
            if (idle) begin
               phase_in = PH_FAST_LOW;
               tick_in  = '0;
               level_in = 1'b0;
            end
         end
         OP_FIVE: begin
            if (idle) begin
               shift_in     = add_parity(addr, cfg.functional_mode);
               phase_in     = PH_FB_START;
               bit_index_in = 4'd0;
               tick_in      = '0;
               level_in     = 1'b0;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   assign line_high = level_in;
   assign busy      = (phase_in != PH_IDLE);
   assign done      = done_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_index_ff <= 4'd0;
         shift_ff     <= '0;
         tick_ff      <= '0;
         level_ff     <= 1'b1;
      end else if (fire) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         tick_ff      <= tick_in;
         level_ff     <= level_in;
      end
   end

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && done_c) |-> !busy)
      else $error("sequence end reported while still busy");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> level_ff)
      else $error("line low while idle");

   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd8)
      else $error("bit index past stop bit");

   a_start_ignored_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && (op == OP_FAST || op == OP_FIVE) && phase_ff != PH_IDLE) |=> $stable(phase_ff))
      else $error("start accepted while busy");

endmodule

>>> rtl/kline_init_line_driver_unit.sv
`timescale 1ns / 1ps

// K-line initialization line driver.
// Request channel (req_valid / req_stall): req_operation selects a time tick,
// a fast-init start, or a five-baud address start with req_address.
// Response channel (rsp_valid / rsp_stall): one transaction per request with
// the line level, the busy flag and the end-of-sequence flag after that item.
// CSR channel (csr_valid / csr_ready): register writes, always ready; write
// only while no request is in flight.
// A request passes the input register, then the sequencer update lands in
// the response register. One request per cycle is sustained unless rsp_stall
// holds it; the limit is the single sequencer state update per cycle.
// Reset is synchronous and returns the line high, idle, with default timing.
// A stalled response holds its register; the input register still takes one
// more request, after which req_stall is raised until the response drains.
module kline_init_line_driver_unit #(
   parameter int COUNTER_WIDTH = kline_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [kline_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [kline_pkg::ADDR_WIDTH-1:0]       req_address,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_line_high,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kline_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kline_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import kline_pkg::*;

   cfg_type               cfg;
   logic                  in_valid_ff, in_valid_in;
   op_type                in_op_ff;
   logic [ADDR_WIDTH-1:0] in_addr_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  line_ff, busy_ff, done_ff;
   logic                  out_free;
   logic                  fire;
   logic                  take;
   logic                  seq_line, seq_busy, seq_done;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign take        = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   kline_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kline_seq #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .op        (in_op_ff),
      .addr      (in_addr_ff),
      .cfg       (cfg),
      .line_high (seq_line),
      .busy      (seq_busy),
      .done      (seq_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_operation;
         in_addr_ff <= req_address;
      end
      if (fire) begin
         line_ff <= seq_line;
         busy_ff <= seq_busy;
         done_ff <= seq_done;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_line_high = line_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;

endmodule
